@@ rtl/core/llcp_pkg.sv @@
`timescale 1ns / 1ps
package llcp_pkg;
    localparam int W_COORD   = 32;
    localparam int W_DIFF    = 33;
    localparam int W_PROD    = 66;
    localparam int W_DOT     = 68;
    localparam int W_WIDE    = 136;
    localparam int W_TOL     = 16;
    localparam int W_CFG_IDX = 2;

    typedef logic [2:0][W_COORD-1:0] t_cvec;
    typedef logic [2:0][W_DIFF-1:0]  t_dvec;

    typedef enum logic [W_CFG_IDX-1:0] {
        REG_VEC_TOL = 2'd0,
        REG_DEN_TOL = 2'd1
    } t_cfg_reg;
endpackage

@@ rtl/core/llcp_in_if.sv @@
`timescale 1ns / 1ps
interface llcp_in_if import llcp_pkg::*;;
    logic valid;
    logic ready;
    logic signed [W_COORD-1:0] a1_x;
    logic signed [W_COORD-1:0] a1_y;
    logic signed [W_COORD-1:0] a1_z;
    logic signed [W_COORD-1:0] a2_x;
    logic signed [W_COORD-1:0] a2_y;
    logic signed [W_COORD-1:0] a2_z;
    logic signed [W_COORD-1:0] b1_x;
    logic signed [W_COORD-1:0] b1_y;
    logic signed [W_COORD-1:0] b1_z;
    logic signed [W_COORD-1:0] b2_x;
    logic signed [W_COORD-1:0] b2_y;
    logic signed [W_COORD-1:0] b2_z;

    modport source (
        output valid, a1_x, a1_y, a1_z, a2_x, a2_y, a2_z,
        output b1_x, b1_y, b1_z, b2_x, b2_y, b2_z,
        input  ready
    );
    modport sink (
        input  valid, a1_x, a1_y, a1_z, a2_x, a2_y, a2_z,
        input  b1_x, b1_y, b1_z, b2_x, b2_y, b2_z,
        output ready
    );
endinterface

@@ rtl/core/llcp_out_if.sv @@
`timescale 1ns / 1ps
interface llcp_out_if import llcp_pkg::*;;
    logic valid;
    logic ready;
    logic found;
    logic signed [W_COORD-1:0] near_a_x;
    logic signed [W_COORD-1:0] near_a_y;
    logic signed [W_COORD-1:0] near_a_z;
    logic signed [W_COORD-1:0] near_b_x;
    logic signed [W_COORD-1:0] near_b_y;
    logic signed [W_COORD-1:0] near_b_z;
    logic signed [W_COORD-1:0] ratio_a;
    logic signed [W_COORD-1:0] ratio_b;

    modport source (
        output valid, found, near_a_x, near_a_y, near_a_z,
        output near_b_x, near_b_y, near_b_z, ratio_a, ratio_b,
        input  ready
    );
    modport sink (
        input  valid, found, near_a_x, near_a_y, near_a_z,
        input  near_b_x, near_b_y, near_b_z, ratio_a, ratio_b,
        output ready
    );
endinterface

@@ rtl/core/llcp_mul.sv @@
`timescale 1ns / 1ps
// Signed multiplier, five stages: magnitude, 32x32 partial products,
// row sums, final sum, sign.
module llcp_mul #(
    parameter int WA = 68,
    parameter int WB = 68
) (
    input  logic                    i_clk,
    input  logic                    i_ce,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int NA = (WA + 31) / 32;
    localparam int NB = (WB + 31) / 32;
    localparam int WP = 32 * (NA + NB);

    logic [WA-1:0]      n_abs_a;
    logic [WB-1:0]      n_abs_b;
    logic [32*NA-1:0]   r_ma;
    logic [32*NB-1:0]   r_mb;
    logic [63:0]        r_pp [NA][NB];
    logic [WP-1:0]      n_row [NA];
    logic [WP-1:0]      r_row [NA];
    logic [WP-1:0]      n_mag;
    logic [WP-1:0]      r_mag;
    logic [WA+WB-1:0]   r_p;
    logic [4:1]         r_ng;

    always_comb begin
        n_abs_a = i_a[WA-1] ? -i_a : i_a;
        n_abs_b = i_b[WB-1] ? -i_b : i_b;
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (WP'(r_pp[i][j]) << (32 * j));
            end
        end
        n_mag = '0;
        for (int i = 0; i < NA; i++) begin
            n_mag = n_mag + (r_row[i] << (32 * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ma  <= (32*NA)'(n_abs_a);
            r_mb  <= (32*NB)'(n_abs_b);
            r_ng[1] <= i_a[WA-1] ^ i_b[WB-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= r_ma[32*i +: 32] * r_mb[32*j +: 32];
                end
            end
            r_ng[2] <= r_ng[1];
            r_row   <= n_row;
            r_ng[3] <= r_ng[2];
            r_mag   <= n_mag;
            r_ng[4] <= r_ng[3];
            r_p     <= r_ng[4] ? -r_mag[WA+WB-1:0] : r_mag[WA+WB-1:0];
        end
    end

    assign o_p = $signed(r_p);
endmodule

@@ rtl/core/llcp_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit a stage. Quotient truncates
// toward zero and saturates to 32 bits.
module llcp_div #(
    parameter int WN = 152,
    parameter int WD = 136
) (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  logic signed [WN-1:0] i_num,
    input  logic signed [WD-1:0] i_den,
    output logic signed [31:0]   o_quo
);
    localparam int WQ = 32;
    localparam int W  = (WN > WD + WQ) ? WN : WD + WQ;
    localparam logic [WQ-1:0] Q_MAX = {1'b0, {(WQ-1){1'b1}}};
    localparam logic [WQ-1:0] Q_MIN = {1'b1, {(WQ-1){1'b0}}};

    logic [WN-1:0] r_mn;
    logic [WD-1:0] r_md;
    logic          r_ng0;
    logic [W-1:0]  r_rem [0:WQ-1];
    logic [WD-1:0] r_dv  [0:WQ-1];
    logic [WQ-1:0] r_q   [0:WQ];
    logic          r_ng  [0:WQ];
    logic          r_ov  [0:WQ];
    logic [WQ-1:0] r_quo;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_mn   <= i_num[WN-1] ? -i_num : i_num;
            r_md   <= i_den[WD-1] ? -i_den : i_den;
            r_ng0  <= i_num[WN-1] ^ i_den[WD-1];
            r_rem[0] <= W'(r_mn);
            r_dv[0]  <= r_md;
            r_q[0]   <= '0;
            r_ng[0]  <= r_ng0;
            r_ov[0]  <= W'(r_mn) >= W'({r_md, {WQ{1'b0}}});
        end
    end

    for (genvar j = 0; j < WQ; j++) begin : g_step
        localparam int B = WQ - 1 - j;
        logic [W-1:0] sh;
        logic         ge;
        assign sh = W'(r_dv[j]) << B;
        assign ge = r_rem[j] >= sh;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q[j+1]  <= r_q[j] | (ge ? (WQ'(1) << B) : '0);
                r_ng[j+1] <= r_ng[j];
                r_ov[j+1] <= r_ov[j];
            end
        end
        if (j < WQ - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[j+1] <= ge ? r_rem[j] - sh : r_rem[j];
                    r_dv[j+1]  <= r_dv[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (!r_ng[WQ]) begin
                r_quo <= (r_ov[WQ] || r_q[WQ][WQ-1]) ? Q_MAX : r_q[WQ];
            end else begin
                r_quo <= (r_ov[WQ] || (r_q[WQ][WQ-1] && |r_q[WQ][WQ-2:0]))
                         ? Q_MIN : -r_q[WQ];
            end
        end
    end

    assign o_quo = $signed(r_quo);
endmodule

@@ rtl/core/line_line_closest_points.sv @@
`timescale 1ns / 1ps
// Closest points between two 3D lines in Q16.16. Fully pipelined: one
// transaction in per clock unless the output stalls. Most pipe depth is in the
// restoring dividers (ratio_a, then ratio_b) and the five-stage multipliers
// ahead of each (68x68, then 68x32). The whole pipe advances whenever the output
// register is empty or being taken, so input ready follows output ready.
// Tolerance registers may be written only while the pipe is empty.
module line_line_closest_points import llcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    llcp_in_if.sink              i_in,
    llcp_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [W_CFG_IDX-1:0] i_cfg_idx,
    input  logic [W_TOL-1:0]     i_cfg_data
);
    localparam int LAST = 88;

    logic                       ce;
    logic [W_TOL-1:0]           r_vec_tol;
    logic [W_TOL-1:0]           r_den_tol;
    logic [1:LAST]              r_vld;

    t_cvec                      n_a1, n_b1;
    t_dvec                      n_p13, n_p43, n_p21;
    t_dvec                      r1_p13;
    t_cvec                      r_a1  [1:49];
    t_cvec                      r_b1  [1:86];
    t_dvec                      r_p21 [1:44];
    t_dvec                      r_p43 [1:85];

    logic signed [W_PROD-1:0]   r2_q1343 [3];
    logic signed [W_PROD-1:0]   r2_q4321 [3];
    logic signed [W_PROD-1:0]   r2_q1321 [3];
    logic signed [W_PROD-1:0]   r2_q4343 [3];
    logic signed [W_PROD-1:0]   r2_q2121 [3];
    logic                       n_nz43, n_nz21;
    logic                       r2_nz43, r2_nz21;
    logic signed [W_TOL+17:0]   vtol;

    logic signed [W_DOT-1:0]    r_d1343 [3:49];
    logic signed [W_DOT-1:0]    r_d4321 [3:44];
    logic signed [W_DOT-1:0]    r3_d1321;
    logic signed [W_DOT-1:0]    r_d4343 [3:50];
    logic signed [W_DOT-1:0]    r3_d2121;
    logic                       r_vf [3:9];

    logic signed [W_WIDE-1:0]   m_den1, m_den2, m_num1, m_num2;
    logic signed [W_WIDE-1:0]   r9_den, r9_num;
    logic signed [W_WIDE-1:0]   thr;
    logic                       r_fail [10:87];

    logic signed [31:0]         ra44, rb85;
    logic signed [31:0]         r_ra [45:87];
    logic signed [31:0]         r_rb [86:87];
    logic signed [W_DOT+31:0]   m_t;
    logic signed [64:0]         r_pa [45:49][3];
    logic signed [W_DOT+32:0]   r50_t;
    logic signed [49:0]         r50_sa [3];
    logic [31:0]                r_pta [51:87][3];
    logic signed [64:0]         r86_pb [3];
    logic signed [49:0]         r87_sb [3];

    logic                       r_found;
    logic [31:0]                r_near_a [3];
    logic [31:0]                r_near_b [3];
    logic [31:0]                r_ra_o, r_rb_o;

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        if ((&v[49:31]) || !(|v[49:31])) begin
            return v[31:0];
        end
        return v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    assign ce         = !r_vld[LAST] || o_out.ready;
    assign i_in.ready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_tol <= W_TOL'(7);
            r_den_tol <= W_TOL'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VEC_TOL: r_vec_tol <= i_cfg_data;
                REG_DEN_TOL: r_den_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {i_in.valid, r_vld[1:LAST-1]};
        end
    end

    // differences
    always_comb begin
        n_a1 = {i_in.a1_z, i_in.a1_y, i_in.a1_x};
        n_b1 = {i_in.b1_z, i_in.b1_y, i_in.b1_x};
        n_p13[0] = W_DIFF'(i_in.a1_x) - W_DIFF'(i_in.b1_x);
        n_p13[1] = W_DIFF'(i_in.a1_y) - W_DIFF'(i_in.b1_y);
        n_p13[2] = W_DIFF'(i_in.a1_z) - W_DIFF'(i_in.b1_z);
        n_p43[0] = W_DIFF'(i_in.b2_x) - W_DIFF'(i_in.b1_x);
        n_p43[1] = W_DIFF'(i_in.b2_y) - W_DIFF'(i_in.b1_y);
        n_p43[2] = W_DIFF'(i_in.b2_z) - W_DIFF'(i_in.b1_z);
        n_p21[0] = W_DIFF'(i_in.a2_x) - W_DIFF'(i_in.a1_x);
        n_p21[1] = W_DIFF'(i_in.a2_y) - W_DIFF'(i_in.a1_y);
        n_p21[2] = W_DIFF'(i_in.a2_z) - W_DIFF'(i_in.a1_z);
    end

    // direction checks on stage 1
    always_comb begin
        vtol   = $signed({18'b0, r_vec_tol});
        n_nz43 = 1'b1;
        n_nz21 = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if ($signed(r_p43[1][i]) > vtol || $signed(r_p43[1][i]) < -vtol) begin
                n_nz43 = 1'b0;
            end
            if ($signed(r_p21[1][i]) > vtol || $signed(r_p21[1][i]) < -vtol) begin
                n_nz21 = 1'b0;
            end
        end
    end

    assign thr = $signed(W_WIDE'({r_den_tol, 48'h0}));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            // stage 1
            r1_p13   <= n_p13;
            r_a1[1]  <= n_a1;
            r_b1[1]  <= n_b1;
            r_p21[1] <= n_p21;
            r_p43[1] <= n_p43;
            for (int k = 2; k <= 49; k++) r_a1[k]  <= r_a1[k-1];
            for (int k = 2; k <= 86; k++) r_b1[k]  <= r_b1[k-1];
            for (int k = 2; k <= 44; k++) r_p21[k] <= r_p21[k-1];
            for (int k = 2; k <= 85; k++) r_p43[k] <= r_p43[k-1];

            // stage 2: component products
            for (int i = 0; i < 3; i++) begin
                r2_q1343[i] <= $signed(r1_p13[i]) * $signed(r_p43[1][i]);
                r2_q4321[i] <= $signed(r_p43[1][i]) * $signed(r_p21[1][i]);
                r2_q1321[i] <= $signed(r1_p13[i]) * $signed(r_p21[1][i]);
                r2_q4343[i] <= $signed(r_p43[1][i]) * $signed(r_p43[1][i]);
                r2_q2121[i] <= $signed(r_p21[1][i]) * $signed(r_p21[1][i]);
            end
            r2_nz43 <= n_nz43;
            r2_nz21 <= n_nz21;

            // stage 3: dot products
            r_d1343[3] <= r2_q1343[0] + r2_q1343[1] + r2_q1343[2];
            r_d4321[3] <= r2_q4321[0] + r2_q4321[1] + r2_q4321[2];
            r3_d1321   <= r2_q1321[0] + r2_q1321[1] + r2_q1321[2];
            r_d4343[3] <= r2_q4343[0] + r2_q4343[1] + r2_q4343[2];
            r3_d2121   <= r2_q2121[0] + r2_q2121[1] + r2_q2121[2];
            r_vf[3]    <= r2_nz43 || r2_nz21;
            for (int k = 4; k <= 49; k++) r_d1343[k] <= r_d1343[k-1];
            for (int k = 4; k <= 44; k++) r_d4321[k] <= r_d4321[k-1];
            for (int k = 4; k <= 50; k++) r_d4343[k] <= r_d4343[k-1];
            for (int k = 4; k <= 9; k++)  r_vf[k]    <= r_vf[k-1];

            // stage 9: denominator and numerator
            r9_den <= m_den1 - m_den2;
            r9_num <= m_num1 - m_num2;

            // stage 10: parallel-line and zero-direction check
            r_fail[10] <= r_vf[9] || (r9_den <= thr && r9_den >= -thr);
            for (int k = 11; k <= 87; k++) r_fail[k] <= r_fail[k-1];

            // stages 45..51: point on line A, t for ratio_b
            r_ra[45] <= ra44;
            for (int k = 46; k <= 87; k++) r_ra[k] <= r_ra[k-1];
            for (int i = 0; i < 3; i++) begin
                r_pa[45][i] <= $signed(r_p21[44][i]) * ra44;
                for (int k = 46; k <= 49; k++) r_pa[k][i] <= r_pa[k-1][i];
                r50_sa[i] <= $signed(r_a1[49][i]) + $signed(r_pa[49][i][64:16]);
                r_pta[51][i] <= sat32(r50_sa[i]);
                for (int k = 52; k <= 87; k++) r_pta[k][i] <= r_pta[k-1][i];
            end
            r50_t <= $signed({r_d1343[49], 16'h0}) + m_t;

            // stages 86..87: point on line B
            r_rb[86] <= rb85;
            r_rb[87] <= r_rb[86];
            for (int i = 0; i < 3; i++) begin
                r86_pb[i] <= $signed(r_p43[85][i]) * rb85;
                r87_sb[i] <= $signed(r_b1[86][i]) + $signed(r86_pb[i][64:16]);
            end

            // stage 88: output register, zeroed on failure
            r_found <= !r_fail[87];
            r_ra_o  <= r_fail[87] ? '0 : r_ra[87];
            r_rb_o  <= r_fail[87] ? '0 : r_rb[87];
            for (int i = 0; i < 3; i++) begin
                r_near_a[i] <= r_fail[87] ? '0 : r_pta[87][i];
                r_near_b[i] <= r_fail[87] ? '0 : sat32(r87_sb[i]);
            end
        end
    end

    llcp_mul #(.WA(W_DOT), .WB(W_DOT)) u_mul_den1 (
        .i_clk(i_clk), .i_ce(ce), .i_a(r3_d2121), .i_b(r_d4343[3]), .o_p(m_den1)
    );
    llcp_mul #(.WA(W_DOT), .WB(W_DOT)) u_mul_den2 (
        .i_clk(i_clk), .i_ce(ce), .i_a(r_d4321[3]), .i_b(r_d4321[3]), .o_p(m_den2)
    );
    llcp_mul #(.WA(W_DOT), .WB(W_DOT)) u_mul_num1 (
        .i_clk(i_clk), .i_ce(ce), .i_a(r_d1343[3]), .i_b(r_d4321[3]), .o_p(m_num1)
    );
    llcp_mul #(.WA(W_DOT), .WB(W_DOT)) u_mul_num2 (
        .i_clk(i_clk), .i_ce(ce), .i_a(r3_d1321), .i_b(r_d4343[3]), .o_p(m_num2)
    );

    llcp_div #(.WN(W_WIDE + 16), .WD(W_WIDE)) u_div_a (
        .i_clk(i_clk), .i_ce(ce), .i_num($signed({r9_num, 16'h0})), .i_den(r9_den),
        .o_quo(ra44)
    );

    llcp_mul #(.WA(W_DOT), .WB(32)) u_mul_t (
        .i_clk(i_clk), .i_ce(ce), .i_a(r_d4321[44]), .i_b(ra44), .o_p(m_t)
    );

    llcp_div #(.WN(W_DOT + 33), .WD(W_DOT)) u_div_b (
        .i_clk(i_clk), .i_ce(ce), .i_num(r50_t), .i_den(r_d4343[50]), .o_quo(rb85)
    );

    assign o_out.valid    = r_vld[LAST];
    assign o_out.found    = r_found;
    assign o_out.near_a_x = r_near_a[0];
    assign o_out.near_a_y = r_near_a[1];
    assign o_out.near_a_z = r_near_a[2];
    assign o_out.near_b_x = r_near_b[0];
    assign o_out.near_b_y = r_near_b[1];
    assign o_out.near_b_z = r_near_b[2];
    assign o_out.ratio_a  = r_ra_o;
    assign o_out.ratio_b  = r_rb_o;

`ifndef NO_ASSERTIONS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[1])
        else $error("accepted transaction did not enter the pipe");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ce |=> $stable(r_vld))
        else $error("pipe moved while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |->
            (o_out.ratio_a == 0 && o_out.ratio_b == 0 &&
             o_out.near_a_x == 0 && o_out.near_b_z == 0))
        else $error("failed result carries non-zero fields");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid straight after reset");
`endif
endmodule
